// ===== hdl/mlfq_pkg.sv =====
// ---------------------------------------------------------------------------
// mlfq_pkg: shared types and constants of the feedback queue scheduler
// Sizes, item structs, slot table entry, sequencer states and codes.
// ---------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int LEVELS     = 3;
  localparam int SLOT_W     = $clog2(MAX_PROCS);
  localparam int LVL_W      = 2;
  localparam int ID_W       = 10;
  localparam int TIME_W     = 16;
  localparam int QUANT_W    = 8;
  localparam int CNT_W      = SLOT_W + 1;
  localparam int QDEPTH     = LEVELS * MAX_PROCS;
  localparam int QADDR_W    = $clog2(QDEPTH);
  localparam int CFG_ADDR_W = 2;

  localparam logic [QUANT_W-1:0] QUANT_TOP_RST    = QUANT_W'(1);
  localparam logic [QUANT_W-1:0] QUANT_MIDDLE_RST = QUANT_W'(2);
  localparam logic [QUANT_W-1:0] QUANT_BOTTOM_RST = QUANT_W'(4);
  localparam logic [QUANT_W-1:0] SLICE_MAX        = '1;

  localparam logic [LVL_W-1:0] LVL_TOP    = LVL_W'(0);
  localparam logic [LVL_W-1:0] LVL_MIDDLE = LVL_W'(1);
  localparam logic [LVL_W-1:0] LVL_BOTTOM = LVL_W'(LEVELS - 1);

  localparam logic [CFG_ADDR_W-1:0] CFG_QUANT_TOP    = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_QUANT_MIDDLE = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_QUANT_BOTTOM = CFG_ADDR_W'(2);

  typedef enum logic {
    OP_ADMIT = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_QREAD,
    S_SREAD,
    S_EXEC
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] burst;
  } sched_in_t;

  typedef struct packed {
    logic              accepted;
    logic              run_valid;
    logic [ID_W-1:0]   run_proc;
    logic [LVL_W-1:0]  run_level;
    logic [TIME_W-1:0] remaining_after;
    logic              finished;
    logic              demoted;
    logic              preempted;
  } sched_out_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] remaining;
    logic [LVL_W-1:0]  level;
  } slot_entry_t;

endpackage

// ===== hdl/mlfq_process_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// mlfq_process_scheduler_unit: three-level feedback queue scheduler
// Admits processes into a slot table and runs one time unit per tick item.
// ---------------------------------------------------------------------------
// An item is taken at a clock edge with start high and busy low. cmd.op
// selects admit (store proc_id/burst at the tail of the top level) or tick
// (run the chosen process for one unit). Every item gives one result on
// result, marked by done for a single cycle; the receiver takes it there
// and cannot hold it off.
// Path of an item: an admit is answered from idle; a tick runs CHECK, EXEC
// while the same process keeps running, CHECK, QREAD (queue memory read),
// SREAD (slot table read), EXEC when a new head is taken, and CHECK alone
// for an empty tick. busy is high while a tick is under way, so no new item
// is taken before it ends; an admit leaves busy low.
// Quantum registers go through cfg_valid/cfg_ready (always ready) at
// cfg_addr 0 top, 1 middle, 2 bottom; other addresses are dropped. Write
// them only while the block is idle.
// Reset (rst, synchronous) empties all queues, frees all slots, stops the
// running process and loads quanta 1, 2 and 4. No clearing pass is needed.
// ---------------------------------------------------------------------------
module mlfq_process_scheduler_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  mlfq_pkg::sched_in_t               cmd,
  output logic                              done,
  output mlfq_pkg::sched_out_t              result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mlfq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mlfq_pkg::QUANT_W-1:0]      cfg_data
);

  mlfq_pkg::state_t state;
  mlfq_pkg::state_t state_next;

  logic [mlfq_pkg::QUANT_W-1:0] quantum_top;
  logic [mlfq_pkg::QUANT_W-1:0] quantum_middle;
  logic [mlfq_pkg::QUANT_W-1:0] quantum_bottom;

  logic [mlfq_pkg::MAX_PROCS-1:0] free_slots;
  logic [mlfq_pkg::SLOT_W-1:0]    q_head  [mlfq_pkg::LEVELS];
  logic [mlfq_pkg::SLOT_W-1:0]    q_tail  [mlfq_pkg::LEVELS];
  logic [mlfq_pkg::CNT_W-1:0]     q_count [mlfq_pkg::LEVELS];

  logic                          running_valid;
  logic [mlfq_pkg::SLOT_W-1:0]   running_slot;
  logic [mlfq_pkg::QUANT_W-1:0]  slice_used;
  logic [mlfq_pkg::ID_W-1:0]     cur_id;
  logic [mlfq_pkg::TIME_W-1:0]   cur_rem;
  logic [mlfq_pkg::LVL_W-1:0]    cur_lvl;
  logic                          preempt_flag;

  // slot table and per-level queue storage
  mlfq_pkg::slot_entry_t        slot_mem [mlfq_pkg::MAX_PROCS];
  mlfq_pkg::slot_entry_t        slot_rd;
  logic [mlfq_pkg::SLOT_W-1:0]  queue_mem [mlfq_pkg::QDEPTH];
  logic [mlfq_pkg::SLOT_W-1:0]  queue_rd;

  // control
  logic accept, admit_go, tick_go;
  logic free_any;
  logic [mlfq_pkg::SLOT_W-1:0] free_idx;
  logic pick_any;
  logic [mlfq_pkg::LVL_W-1:0] pick_lvl;
  logic do_preempt, need_pick;

  logic                         slot_we;
  logic [mlfq_pkg::SLOT_W-1:0]  slot_waddr;
  mlfq_pkg::slot_entry_t        slot_wdata;
  logic                         slot_re;
  logic                         q_we;
  logic [mlfq_pkg::LVL_W-1:0]   q_wlvl;
  logic [mlfq_pkg::SLOT_W-1:0]  q_wslot;
  logic                         q_re;

  // shared execute unit
  logic [mlfq_pkg::TIME_W-1:0]  rem_dec;
  logic [mlfq_pkg::QUANT_W-1:0] slice_inc;
  logic [mlfq_pkg::QUANT_W-1:0] quant_sel;
  logic [mlfq_pkg::LVL_W-1:0]   next_lvl;
  logic                         hit_finish;
  logic                         hit_slice;

  assign cfg_ready = 1'b1;

  assign busy     = (state != mlfq_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign admit_go = accept && (cmd.op == mlfq_pkg::OP_ADMIT);
  assign tick_go  = accept && (cmd.op == mlfq_pkg::OP_TICK);

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = mlfq_pkg::MAX_PROCS - 1; i >= 0; i--) begin
      if (free_slots[i]) begin
        free_any = 1'b1;
        free_idx = mlfq_pkg::SLOT_W'(i);
      end
    end
  end

  // highest non-empty level
  always_comb begin
    pick_any = 1'b0;
    pick_lvl = '0;
    for (int l = mlfq_pkg::LEVELS - 1; l >= 0; l--) begin
      if (q_count[l] != '0) begin
        pick_any = 1'b1;
        pick_lvl = mlfq_pkg::LVL_W'(l);
      end
    end
  end

  assign do_preempt = running_valid && (cur_lvl != mlfq_pkg::LVL_TOP) &&
                      (q_count[0] != '0);
  assign need_pick  = !running_valid || do_preempt;

  always_comb begin
    case (cur_lvl)
      mlfq_pkg::LVL_TOP:    quant_sel = quantum_top;
      mlfq_pkg::LVL_BOTTOM: quant_sel = quantum_bottom;
      default:              quant_sel = quantum_middle;
    endcase
  end

  assign rem_dec    = (cur_rem != '0) ? cur_rem - mlfq_pkg::TIME_W'(1) : '0;
  assign slice_inc  = (slice_used != mlfq_pkg::SLICE_MAX) ?
                      slice_used + mlfq_pkg::QUANT_W'(1) : slice_used;
  assign hit_finish = (rem_dec == '0);
  // a zero quantum acts as one: slice_inc is never below one
  assign hit_slice  = (slice_inc >= quant_sel);
  assign next_lvl   = (cur_lvl == mlfq_pkg::LVL_BOTTOM) ? cur_lvl :
                      cur_lvl + mlfq_pkg::LVL_W'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mlfq_pkg::S_IDLE: begin
        if (tick_go) state_next = mlfq_pkg::S_CHECK;
      end
      mlfq_pkg::S_CHECK: begin
        if (!need_pick)    state_next = mlfq_pkg::S_EXEC;
        else if (pick_any) state_next = mlfq_pkg::S_QREAD;
        else               state_next = mlfq_pkg::S_IDLE;
      end
      mlfq_pkg::S_QREAD: state_next = mlfq_pkg::S_SREAD;
      mlfq_pkg::S_SREAD: state_next = mlfq_pkg::S_EXEC;
      mlfq_pkg::S_EXEC:  state_next = mlfq_pkg::S_IDLE;
      default:           state_next = mlfq_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = running_slot;
    slot_wdata = '{id: cur_id, remaining: cur_rem, level: cur_lvl};
    slot_re    = 1'b0;
    q_we       = 1'b0;
    q_wlvl     = cur_lvl;
    q_wslot    = running_slot;
    q_re       = 1'b0;
    case (state)
      mlfq_pkg::S_IDLE: begin
        if (admit_go && free_any) begin
          slot_we    = 1'b1;
          slot_waddr = free_idx;
          slot_wdata = '{id: cmd.proc_id,
                         remaining: (cmd.burst == '0) ? mlfq_pkg::TIME_W'(1) : cmd.burst,
                         level: mlfq_pkg::LVL_TOP};
          q_we    = 1'b1;
          q_wlvl  = mlfq_pkg::LVL_TOP;
          q_wslot = free_idx;
        end
      end
      mlfq_pkg::S_CHECK: begin
        // hand the running process back to its own tail
        if (do_preempt) begin
          slot_we = 1'b1;
          q_we    = 1'b1;
        end
        q_re = need_pick && pick_any;
      end
      mlfq_pkg::S_QREAD: slot_re = 1'b1;
      mlfq_pkg::S_EXEC: begin
        if (!hit_finish && hit_slice) begin
          slot_we    = 1'b1;
          slot_wdata = '{id: cur_id, remaining: rem_dec, level: next_lvl};
          q_we       = 1'b1;
          q_wlvl     = next_lvl;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rd <= slot_mem[queue_rd];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[mlfq_pkg::QADDR_W'({q_wlvl, q_tail[q_wlvl]})] <= q_wslot;
    if (q_re) queue_rd <= queue_mem[mlfq_pkg::QADDR_W'({pick_lvl, q_head[pick_lvl]})];
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
        q_head[l]  <= '0;
        q_tail[l]  <= '0;
        q_count[l] <= '0;
      end
    end else begin
      for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
        if (q_we && (q_wlvl == mlfq_pkg::LVL_W'(l))) begin
          q_tail[l] <= (q_tail[l] == mlfq_pkg::SLOT_W'(mlfq_pkg::MAX_PROCS - 1)) ?
                       '0 : q_tail[l] + mlfq_pkg::SLOT_W'(1);
        end
        if (q_re && (pick_lvl == mlfq_pkg::LVL_W'(l))) begin
          q_head[l] <= (q_head[l] == mlfq_pkg::SLOT_W'(mlfq_pkg::MAX_PROCS - 1)) ?
                       '0 : q_head[l] + mlfq_pkg::SLOT_W'(1);
        end
        if ((q_we && (q_wlvl == mlfq_pkg::LVL_W'(l))) &&
            !(q_re && (pick_lvl == mlfq_pkg::LVL_W'(l)))) begin
          q_count[l] <= q_count[l] + mlfq_pkg::CNT_W'(1);
        end else if (!(q_we && (q_wlvl == mlfq_pkg::LVL_W'(l))) &&
                     (q_re && (pick_lvl == mlfq_pkg::LVL_W'(l)))) begin
          q_count[l] <= q_count[l] - mlfq_pkg::CNT_W'(1);
        end
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_top    <= mlfq_pkg::QUANT_TOP_RST;
      quantum_middle <= mlfq_pkg::QUANT_MIDDLE_RST;
      quantum_bottom <= mlfq_pkg::QUANT_BOTTOM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        mlfq_pkg::CFG_QUANT_TOP:    quantum_top    <= cfg_data;
        mlfq_pkg::CFG_QUANT_MIDDLE: quantum_middle <= cfg_data;
        mlfq_pkg::CFG_QUANT_BOTTOM: quantum_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, running process and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mlfq_pkg::S_IDLE;
      free_slots    <= '1;
      running_valid <= 1'b0;
      running_slot  <= '0;
      slice_used    <= '0;
      preempt_flag  <= 1'b0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= admit_go ||
               ((state == mlfq_pkg::S_CHECK) && need_pick && !pick_any) ||
               (state == mlfq_pkg::S_EXEC);
      case (state)
        mlfq_pkg::S_IDLE: begin
          if (admit_go) begin
            if (free_any) free_slots[free_idx] <= 1'b0;
            result <= '{accepted: free_any, run_valid: 1'b0, run_proc: '0,
                        run_level: '0, remaining_after: '0, finished: 1'b0,
                        demoted: 1'b0, preempted: 1'b0};
          end
          if (tick_go) preempt_flag <= 1'b0;
        end
        mlfq_pkg::S_CHECK: begin
          preempt_flag <= do_preempt;
          if (do_preempt) begin
            running_valid <= 1'b0;
            slice_used    <= '0;
          end
          if (need_pick && !pick_any) begin
            // idle tick
            result <= '0;
          end
        end
        mlfq_pkg::S_QREAD: running_slot <= queue_rd;
        mlfq_pkg::S_SREAD: begin
          cur_id        <= slot_rd.id;
          cur_rem       <= slot_rd.remaining;
          cur_lvl       <= slot_rd.level;
          running_valid <= 1'b1;
          slice_used    <= '0;
        end
        mlfq_pkg::S_EXEC: begin
          result <= '{accepted: 1'b0, run_valid: 1'b1, run_proc: cur_id,
                      run_level: cur_lvl, remaining_after: rem_dec,
                      finished: hit_finish, demoted: !hit_finish && hit_slice,
                      preempted: preempt_flag};
          if (hit_finish) begin
            free_slots[running_slot] <= 1'b1;
            running_valid            <= 1'b0;
            slice_used               <= '0;
          end else if (hit_slice) begin
            running_valid <= 1'b0;
            slice_used    <= '0;
          end else begin
            cur_rem    <= rem_dec;
            slice_used <= slice_inc;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== verif/tb_mlfq_process_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// tb_mlfq_process_scheduler_unit: testbench of the feedback queue scheduler
// Sends admit and tick items through the start/busy port, keeps its own
// model of slots, level queues and the running process, and compares every
// result against the decision that model makes for the same item.
// ---------------------------------------------------------------------------
module tb_mlfq_process_scheduler_unit;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  mlfq_pkg::sched_in_t             cmd = '0;
  logic                            done;
  mlfq_pkg::sched_out_t            result;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mlfq_pkg::CFG_ADDR_W-1:0] cfg_addr = mlfq_pkg::CFG_QUANT_TOP;
  logic [mlfq_pkg::QUANT_W-1:0]    cfg_data = '0;

  mlfq_process_scheduler_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Scheduler shadow: slot table, level rings, running process, quanta
  logic [mlfq_pkg::ID_W-1:0]    tbl_pid  [mlfq_pkg::MAX_PROCS];
  logic [mlfq_pkg::TIME_W-1:0]  tbl_left [mlfq_pkg::MAX_PROCS];
  logic [mlfq_pkg::LVL_W-1:0]   tbl_lvl  [mlfq_pkg::MAX_PROCS];
  bit                           tbl_free [mlfq_pkg::MAX_PROCS] = '{default: 1'b1};
  int                           rq_mem   [mlfq_pkg::LEVELS][mlfq_pkg::MAX_PROCS];
  int                           rq_head  [mlfq_pkg::LEVELS] = '{default: 0};
  int                           rq_tail  [mlfq_pkg::LEVELS] = '{default: 0};
  int                           rq_count [mlfq_pkg::LEVELS] = '{default: 0};
  bit                           cur_valid = 1'b0;
  int                           cur_slot = 0;
  int                           cur_ticks = 0;
  int                           live_procs = 0;
  logic [mlfq_pkg::QUANT_W-1:0] qtm [3] = '{mlfq_pkg::QUANT_TOP_RST,
                                             mlfq_pkg::QUANT_MIDDLE_RST,
                                             mlfq_pkg::QUANT_BOTTOM_RST};

  mlfq_pkg::sched_out_t sched_decisions [$];
  int                   fault_count = 0;
  int                   cycle_count = 0;
  int                   gap_pct = 0;

  function automatic void enqueue(int lv, int s);
    rq_mem[lv][rq_tail[lv]] = s;
    rq_tail[lv] = (rq_tail[lv] + 1) % mlfq_pkg::MAX_PROCS;
    rq_count[lv]++;
  endfunction

  function automatic mlfq_pkg::sched_out_t decide_item(mlfq_pkg::sched_in_t c);
    mlfq_pkg::sched_out_t r;
    int s;
    int lv;
    int nl;
    int q;
    r = '0;
    if (c.op == mlfq_pkg::OP_ADMIT) begin
      s = -1;
      for (int i = mlfq_pkg::MAX_PROCS - 1; i >= 0; i--)
        if (tbl_free[i]) s = i;
      if (s < 0) return r;
      tbl_free[s] = 1'b0;
      tbl_pid[s]  = c.proc_id;
      tbl_left[s] = (c.burst == '0) ? mlfq_pkg::TIME_W'(1) : c.burst;
      tbl_lvl[s]  = mlfq_pkg::LVL_TOP;
      enqueue(int'(mlfq_pkg::LVL_TOP), s);
      live_procs++;
      r.accepted = 1'b1;
      return r;
    end
    // a waiting top-level process displaces a lower-level runner
    if (cur_valid && tbl_lvl[cur_slot] != mlfq_pkg::LVL_TOP &&
        rq_count[mlfq_pkg::LVL_TOP] > 0) begin
      enqueue(int'(tbl_lvl[cur_slot]), cur_slot);
      cur_valid = 1'b0;
      cur_ticks = 0;
      r.preempted = 1'b1;
    end
    if (!cur_valid) begin
      lv = 0;
      while (lv < mlfq_pkg::LEVELS && rq_count[lv] == 0) lv++;
      if (lv == mlfq_pkg::LEVELS) return r;
      cur_slot = rq_mem[lv][rq_head[lv]];
      rq_head[lv] = (rq_head[lv] + 1) % mlfq_pkg::MAX_PROCS;
      rq_count[lv]--;
      cur_valid = 1'b1;
      cur_ticks = 0;
    end
    s  = cur_slot;
    lv = int'(tbl_lvl[s]);
    if (tbl_left[s] != '0) tbl_left[s]--;
    if (cur_ticks < 255) cur_ticks++;
    r.run_valid       = 1'b1;
    r.run_proc        = tbl_pid[s];
    r.run_level       = tbl_lvl[s];
    r.remaining_after = tbl_left[s];
    q = (lv == int'(mlfq_pkg::LVL_TOP)) ? int'(qtm[mlfq_pkg::CFG_QUANT_TOP]) :
        (lv >= mlfq_pkg::LEVELS - 1) ? int'(qtm[mlfq_pkg::CFG_QUANT_BOTTOM]) :
        int'(qtm[mlfq_pkg::CFG_QUANT_MIDDLE]);
    if (q == 0) q = 1;
    if (tbl_left[s] == '0) begin
      r.finished  = 1'b1;
      tbl_free[s] = 1'b1;
      live_procs--;
      cur_valid   = 1'b0;
      cur_ticks   = 0;
    end else if (cur_ticks >= q) begin
      nl = (lv + 1 < mlfq_pkg::LEVELS) ? lv + 1 : mlfq_pkg::LEVELS - 1;
      r.demoted  = 1'b1;
      tbl_lvl[s] = mlfq_pkg::LVL_W'(nl);
      enqueue(nl, s);
      cur_valid  = 1'b0;
      cur_ticks  = 0;
    end
    return r;
  endfunction

  function automatic string show(mlfq_pkg::sched_out_t r);
    return $sformatf("acc %0b run %0b proc %0d lvl %0d left %0d fin %0b dem %0b pre %0b",
                     r.accepted, r.run_valid, r.run_proc, r.run_level,
                     r.remaining_after, r.finished, r.demoted, r.preempted);
  endfunction

  always @(posedge clk) begin : check_results
    mlfq_pkg::sched_out_t want;
    if (!rst && done) begin
      if (sched_decisions.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("result with no pending item: %s", show(result));
      end else begin
        want = sched_decisions.pop_front();
        if (result.accepted !== want.accepted || result.run_valid !== want.run_valid ||
            result.run_proc !== want.run_proc || result.run_level !== want.run_level ||
            result.remaining_after !== want.remaining_after ||
            result.finished !== want.finished || result.demoted !== want.demoted ||
            result.preempted !== want.preempted) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("result mismatch: expected %s, got %s", show(want), show(result));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold start low until every result is in, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    while (sched_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leave start high on return so back-to-back items need no second drive
  task automatic send_item(mlfq_pkg::sched_in_t c);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sched_decisions.push_back(decide_item(c));
  endtask

  task automatic issue(mlfq_pkg::op_t op, logic [mlfq_pkg::ID_W-1:0] id,
                       logic [mlfq_pkg::TIME_W-1:0] burst);
    mlfq_pkg::sched_in_t c;
    c.op      = op;
    c.proc_id = id;
    c.burst   = burst;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
      idle($urandom_range(1, 15));
    send_item(c);
  endtask

  task automatic write_quantum(logic [mlfq_pkg::CFG_ADDR_W-1:0] addr,
                               logic [mlfq_pkg::QUANT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    qtm[addr] = data;
  endtask

  task automatic set_quanta(int top, int middle, int bottom);
    drain();
    write_quantum(mlfq_pkg::CFG_QUANT_TOP, mlfq_pkg::QUANT_W'(top));
    write_quantum(mlfq_pkg::CFG_QUANT_MIDDLE, mlfq_pkg::QUANT_W'(middle));
    write_quantum(mlfq_pkg::CFG_QUANT_BOTTOM, mlfq_pkg::QUANT_W'(bottom));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count, int tick_pct, bit wide);
    int pick;
    logic [mlfq_pkg::TIME_W-1:0] burst;
    if (wide) gap_pct = 0;
    for (int n = 0; n < count; n++) begin
      if (!wide && n % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 50;
        endcase
      end
      if ($urandom_range(1, 100) <= tick_pct) begin
        issue(mlfq_pkg::OP_TICK, mlfq_pkg::ID_W'($urandom_range(0, 1023)),
              mlfq_pkg::TIME_W'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (wide && pick < 12)   burst = mlfq_pkg::TIME_W'($urandom_range(0, 65535));
        else if (pick < 3)       burst = '0;
        else if (pick < 80)      burst = mlfq_pkg::TIME_W'($urandom_range(1, 12));
        else                     burst = mlfq_pkg::TIME_W'($urandom_range(13, 300));
        issue(mlfq_pkg::OP_ADMIT, mlfq_pkg::ID_W'($urandom_range(0, 1023)), burst);
      end
    end
  endtask

  task automatic test_empty_tick();
    gap_pct = 30;
    issue(mlfq_pkg::OP_TICK, '1, '1);
  endtask

  // Zero id and burst, demotion, duplicate id, top-level preemption
  task automatic test_admit_and_run();
    issue(mlfq_pkg::OP_ADMIT, '0, '0);
    issue(mlfq_pkg::OP_TICK, '0, '0);
    issue(mlfq_pkg::OP_ADMIT, 10'd1023, 16'd3);
    issue(mlfq_pkg::OP_TICK, '0, '0);
    issue(mlfq_pkg::OP_TICK, '0, '0);
    issue(mlfq_pkg::OP_ADMIT, 10'd1023, 16'd2);
    issue(mlfq_pkg::OP_TICK, '0, '0);
    issue(mlfq_pkg::OP_TICK, '0, '0);
    issue(mlfq_pkg::OP_TICK, '0, '0);
  endtask

  // Fill every slot, then one admit more must be turned away
  task automatic test_table_full();
    while (live_procs < mlfq_pkg::MAX_PROCS)
      issue(mlfq_pkg::OP_ADMIT, mlfq_pkg::ID_W'($urandom_range(0, 1023)),
            mlfq_pkg::TIME_W'($urandom_range(1, 3)));
    issue(mlfq_pkg::OP_ADMIT, 10'h2AA, 16'h5555);
  endtask

  task automatic test_slice_extremes();
    set_quanta(1, 1, 1);
    run_random(250, 70, 1'b0);
    set_quanta(255, 255, 255);
    run_random(250, 60, 1'b0);
    set_quanta(0, 0, 0);
    run_random(200, 75, 1'b0);
  endtask

  task automatic test_random_quanta();
    repeat (3) begin
      set_quanta($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8));
      run_random(250, $urandom_range(55, 85), 1'b0);
    end
  endtask

  // Last part: no idling, full-range bursts
  task automatic test_wide_fields();
    set_quanta($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 255));
    issue(mlfq_pkg::OP_ADMIT, 10'h3FF, 16'hFFFF);
    run_random(250, 65, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_tick();
    test_admit_and_run();
    test_table_full();
    test_slice_extremes();
    test_random_quanta();
    test_wide_fields();
    drain();
    if (fault_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
